// ----- rtl/core/oasm_pkg.sv -----
// Shared types, constants and helpers for the ordered-alphabet string matcher.
// Used by oasm_cell, the matcher unit, its checker and testbench; depends on nothing.
package oasm_pkg;

    localparam int LEN_W      = 6;    // width of the pattern length register
    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 32;   // bytes held by the four pattern registers
    localparam int PAT_IDX_W  = 5;    // index of one pattern byte
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 32;

    typedef logic [PAT_W-1:0]  t_pattern;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [BYTE_W-1:0] t_byte;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_0_7    = 3'd1,
        CFG_PATTERN_8_15   = 3'd2,
        CFG_PATTERN_16_23  = 3'd3,
        CFG_PATTERN_24_31  = 3'd4
    } t_cfg_reg;

    // Control that every cell of the window receives in each cycle.
    typedef struct packed {
        logic shift;   // a request was taken; move the window by one byte
        logic clear;   // that request ended its text; empty the window
    } t_cell_ctrl;

    // Selects pattern byte idx out of the packed pattern registers.
    function automatic t_byte pattern_byte(input t_pattern pat, input logic [PAT_IDX_W-1:0] idx);
        pattern_byte = pat[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

// ----- rtl/core/oasm_cell.sv -----
// One cell of the text window: holds one recent text byte, passes it on to
// the next cell and compares it with its aligned pattern byte. Uses oasm_pkg.
module oasm_cell #(
    parameter int INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oasm_pkg::t_cell_ctrl i_ctrl,
    input  oasm_pkg::t_byte     i_byte,
    input  oasm_pkg::t_pattern  i_pattern,
    input  oasm_pkg::t_len      i_len,
    output oasm_pkg::t_byte     o_byte,
    output logic                o_hit
);

    oasm_pkg::t_byte               r_byte;
    logic [oasm_pkg::LEN_W:0]      w_idx_full;
    logic [oasm_pkg::LEN_W:0]      w_pos;
    logic                          w_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctrl.clear) begin
            r_byte <= '0;
        end else if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    // The cell takes part when it lies inside the window, that is when
    // INDEX + 1 < length; it then faces pattern byte length - 2 - INDEX.
    always_comb begin
        w_pos      = (oasm_pkg::LEN_W + 1)'(INDEX + 1);
        w_used     = w_pos < {1'b0, i_len};
        w_idx_full = {1'b0, i_len} - w_pos - (oasm_pkg::LEN_W + 1)'(1);
        o_hit      = !w_used ||
                     (r_byte == oasm_pkg::pattern_byte(i_pattern,
                                                       w_idx_full[oasm_pkg::PAT_IDX_W-1:0]));
    end

    assign o_byte = r_byte;

endmodule

// ----- rtl/core/ordered_alphabet_string_match_unit.sv -----
// Ordered-alphabet string matcher: reports the start position of every pattern occurrence.
// Latency: a result is valid in the cycle after the request that completes the occurrence.
// Throughput: one byte per cycle unless the output stalls; the compare is combinational.
// Reset (i_rst_n low, synchronous): pattern length and pattern bytes cleared, window,
// byte count and position cleared, no result pending.
// Depends on oasm_pkg and oasm_cell.
module ordered_alphabet_string_match_unit #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [oasm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [oasm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Text request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_text_byte,
    input  logic                              i_last_of_text,
    // Match result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [31:0]                       o_match_position
);

    // The window keeps PATTERN_MAX-1 earlier bytes, one per cell. At least one
    // cell is built so that the row is never empty; with a one-byte pattern it
    // simply never takes part in the compare.
    localparam int NCELL  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int SEEN_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CMP_W  = oasm_pkg::LEN_W + 1;

    // Configuration registers.
    oasm_pkg::t_len                  r_len;
    oasm_pkg::t_pattern              r_pat;

    // Text bookkeeping: earlier bytes of the current text (saturating at
    // PATTERN_MAX-1) and the position of the next byte (saturating at all ones).
    logic [SEEN_W-1:0]               r_seen;
    logic [oasm_pkg::POS_W-1:0]      r_pos;

    // Output register.
    logic                            r_out_valid;
    logic [oasm_pkg::POS_W-1:0]      r_out_pos;

    logic                            w_accept;
    oasm_pkg::t_cell_ctrl            w_ctrl;
    oasm_pkg::t_byte                 w_chain [NCELL+1];
    logic [NCELL-1:0]                w_hits;
    logic                            w_len_ok;
    logic                            w_enough;
    logic                            w_head;
    logic                            w_hit;
    logic [CMP_W-1:0]                w_len_m1;

    // A request is taken whenever the output register is empty or is being
    // drained in the same cycle; while that holds, the stream runs at one byte per cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctrl.shift = w_accept;
    assign w_ctrl.clear = w_accept && i_last_of_text;

    // Configuration writes. Indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pat <= '0;
        end else if (i_cfg_we) begin
            case (oasm_pkg::t_cfg_reg'(i_cfg_idx))
                oasm_pkg::CFG_PATTERN_LENGTH: r_len <= i_cfg_data[oasm_pkg::LEN_W-1:0];
                oasm_pkg::CFG_PATTERN_0_7:    r_pat[63:0]    <= i_cfg_data;
                oasm_pkg::CFG_PATTERN_8_15:   r_pat[127:64]  <= i_cfg_data;
                oasm_pkg::CFG_PATTERN_16_23:  r_pat[191:128] <= i_cfg_data;
                oasm_pkg::CFG_PATTERN_24_31:  r_pat[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The row of cells. The new byte enters cell 0 and every accepted request
    // moves each byte one cell further, so cell k holds the byte k+1 places back.
    assign w_chain[0] = i_text_byte;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        oasm_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_byte    (w_chain[k]),
            .i_pattern (r_pat),
            .i_len     (r_len),
            .o_byte    (w_chain[k+1]),
            .o_hit     (w_hits[k])
        );
    end

    // An occurrence ends at the new byte when the length is usable, the current
    // text already holds enough bytes, the new byte matches the last pattern
    // byte and every cell inside the window matches its pattern byte.
    always_comb begin
        w_len_m1 = {1'b0, r_len} - CMP_W'(1);
        w_len_ok = (r_len != '0) && ({1'b0, r_len} <= CMP_W'(PATTERN_MAX));
        w_enough = (CMP_W'(r_seen) + CMP_W'(1)) >= {1'b0, r_len};
        w_head   = i_text_byte ==
                   oasm_pkg::pattern_byte(r_pat, w_len_m1[oasm_pkg::PAT_IDX_W-1:0]);
        w_hit    = w_len_ok && w_enough && w_head && (&w_hits);
    end

    // Byte count and position. A text end restarts both at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pos  <= '0;
        end else if (w_accept) begin
            if (i_last_of_text) begin
                r_seen <= '0;
                r_pos  <= '0;
            end else begin
                if (r_seen != SEEN_W'(PATTERN_MAX - 1)) begin
                    r_seen <= r_seen + SEEN_W'(1);
                end
                if (r_pos != '1) begin
                    r_pos <= r_pos + oasm_pkg::POS_W'(1);
                end
            end
        end
    end

    // Output register. The start position is the current byte's position less
    // length minus one, taken from the saturated position when it has saturated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_hit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_hit) begin
            r_out_pos <= r_pos - oasm_pkg::POS_W'(w_len_m1);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_out_pos;

    // A result only appears after a request that was taken.
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept))
        else $error("result appeared without a request");

    // A text end restarts the count and the position.
    a_text_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_of_text) |=> (r_seen == '0 && r_pos == '0))
        else $error("text end did not clear the count and position");

    // The byte count never passes its saturation value.
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_seen) <= CMP_W'(PATTERN_MAX - 1))
        else $error("byte count beyond its limit");

    // A reported start never lies past the position of the byte that ended it.
    a_start_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_hit && !i_last_of_text && r_pos != '1)
            |=> (r_out_pos < r_pos))
        else $error("reported start past the current position");

endmodule

// ----- verif/oasm_match_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ordered-alphabet string matcher: tracks the pattern registers and
// text window, predicts each match position and compares it with the result channel.
// Depends on oasm_pkg.
module oasm_match_checker #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [oasm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [oasm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_last_of_text,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [31:0]                     i_match_position,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked_count
);

    localparam int WINDOW_DEPTH = PATTERN_MAX - 1;

    oasm_pkg::t_len     pat_len;
    oasm_pkg::t_pattern pat_bits;
    oasm_pkg::t_byte    window_bytes [WINDOW_DEPTH];
    int unsigned        bytes_in_text;
    logic [31:0]        next_position;
    logic [31:0]        expected_starts [$];

    task automatic clear_text();
        foreach (window_bytes[i]) window_bytes[i] = '0;
        bytes_in_text = 0;
        next_position = '0;
    endtask

    // Compares the window that ends at the new byte against the pattern, then moves the window.
    task automatic take_text_byte(input oasm_pkg::t_byte b, input logic last);
        int unsigned n;
        bit          hit;
        n = pat_len;
        if (n >= 1 && n <= PATTERN_MAX && bytes_in_text + 1 >= n) begin
            hit = (pat_bits[8*(n-1) +: 8] == b);
            for (int i = 0; i + 1 < n && i < WINDOW_DEPTH; i++) begin
                if (pat_bits[8*(n-2-i) +: 8] != window_bytes[i]) hit = 1'b0;
            end
            if (hit) expected_starts.push_back(next_position - 32'(n - 1));
        end
        if (last) begin
            clear_text();
        end else begin
            for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = b;
            if (bytes_in_text < PATTERN_MAX - 1) bytes_in_text++;
            if (next_position != '1) next_position++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            pat_len         = '0;
            pat_bits        = '0;
            o_fail_count    = 0;
            o_checked_count = 0;
            clear_text();
            expected_starts.delete();
        end else begin
            // A result taken now belongs to a request taken earlier, so check it first.
            if (i_out_valid && i_out_ready) begin
                if (expected_starts.size() == 0) begin
                    $error("match_position: no match expected, actual 0x%08h", i_match_position);
                    o_fail_count++;
                end else begin
                    want = expected_starts.pop_front();
                    o_checked_count++;
                    if (want !== i_match_position) begin
                        $error("match_position: expected 0x%08h, actual 0x%08h",
                               want, i_match_position);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    oasm_pkg::CFG_PATTERN_LENGTH: begin
                        pat_len = i_cfg_data[oasm_pkg::LEN_W-1:0];
                    end
                    oasm_pkg::CFG_PATTERN_0_7, oasm_pkg::CFG_PATTERN_8_15,
                    oasm_pkg::CFG_PATTERN_16_23, oasm_pkg::CFG_PATTERN_24_31: begin
                        pat_bits[oasm_pkg::CFG_DATA_W*(i_cfg_idx - oasm_pkg::CFG_PATTERN_0_7)
                                 +: oasm_pkg::CFG_DATA_W] = i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_text_byte(i_text_byte, i_last_of_text);
        end
        o_pending = expected_starts.size();
    end

endmodule

// ----- verif/ordered_alphabet_string_match_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the string matcher testbench: clock, reset, pattern programming, text stimulus and verdict.
// Depends on oasm_pkg, ordered_alphabet_string_match_unit and oasm_match_checker.
module ordered_alphabet_string_match_unit_tb;

    localparam int PATTERN_MAX  = 32;
    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_CYCLES  = 80;    // long receiver stall that must back up the input
    localparam int STALL_LIMIT  = 1000;  // cycles without any handshake before giving up
    localparam int SETTLE_WAIT  = 3;     // margin after the last predicted result
    localparam int NO_IDLE_ITEMS = 120;  // length of the stretch without any idling

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [oasm_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [oasm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      text_byte = '0;
    logic                            last_of_text = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [31:0]                     match_position;

    int fail_count;
    int pending;
    int checked_count;

    // Stimulus bookkeeping.
    int                 sent_items = 0;
    int                 settings_run = 0;
    int                 cur_len;
    oasm_pkg::t_pattern cur_pattern;
    oasm_pkg::t_byte    alpha [4];
    int                 alpha_size;

    // Idling control shared by the sender and the receiver.
    logic no_idle = 1'b0;
    int   hold_requests = 0;
    int   holds_done = 0;
    int   hold_left = 0;
    int   stalled_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_alphabet_string_match_unit #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_text_byte      (text_byte),
        .i_last_of_text   (last_of_text),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_match_position (match_position)
    );

    oasm_match_checker #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_text_byte      (text_byte),
        .i_last_of_text   (last_of_text),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_match_position (match_position),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked_count  (checked_count)
    );

    // The receiver drops ready about 37 times in a hundred, never during the no-idle
    // stretch, and holds it low for a long run whenever the stimulus asks for a hold.
    // The hold is counted here so that the sender keeps offering requests meanwhile.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES - 1;
            out_ready  <= 1'b0;
        end else if (no_idle) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // Watchdog: any request or result moving, or reset, counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one text byte, after a random number of idle cycles, and returns at the
    // edge where it is taken. Valid is left high so the next request can follow directly.
    task automatic send_text_byte(input oasm_pkg::t_byte b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 37) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= b;
        last_of_text <= last;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    // Stops offering and waits until every predicted match has come out, plus the
    // result latency, so that the registers can be rewritten with the block idle.
    // The first edge lets the checker record the last request before the count is read.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Writes the length and all four pattern words, then one unused index with junk
    // that the block must ignore. The length word carries random upper bits that must
    // be dropped as well.
    task automatic program_matcher(input oasm_pkg::t_len len, input oasm_pkg::t_pattern pat);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        cfg_we   <= 1'b1;
        cfg_idx  <= oasm_pkg::CFG_PATTERN_LENGTH;
        cfg_data <= {junk[63:oasm_pkg::LEN_W], len};
        @(posedge clk);
        for (int k = 0; k < 4; k++) begin
            cfg_idx  <= oasm_pkg::CFG_IDX_W'(oasm_pkg::CFG_PATTERN_0_7 + k);
            cfg_data <= pat[oasm_pkg::CFG_DATA_W*k +: oasm_pkg::CFG_DATA_W];
            @(posedge clk);
        end
        cfg_idx  <= oasm_pkg::CFG_IDX_W'($urandom_range(oasm_pkg::CFG_PATTERN_24_31 + 1,
                                                        (1 << oasm_pkg::CFG_IDX_W) - 1));
        cfg_data <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Builds a pattern of the given length. Random patterns draw their used bytes from a
    // small alphabet so that the text hits them often; the unused bytes are random and
    // must have no effect. The other two shapes fill the pattern with zeros or ones.
    task automatic make_pattern(input int len, input int shape, input int letters);
        if (shape == 1 || shape == 2) begin
            cur_pattern = (shape == 1) ? '0 : '1;
            alpha[0]    = 8'h00;
            alpha[1]    = 8'hFF;
            alpha_size  = 2;
        end else begin
            alpha_size = letters;
            foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
            for (int b = 0; b < oasm_pkg::PAT_BYTES; b++) begin
                cur_pattern[8*b +: 8] = (b < len) ? alpha[$urandom_range(0, alpha_size - 1)]
                                                  : 8'($urandom_range(0, 255));
            end
        end
        cur_len = len;
    endtask

    // Feeds one setting's worth of text. Most of it is copies of the pattern, a quarter of
    // them with one byte damaged, then runs of alphabet bytes and some full-range noise.
    // Texts end at random, also in the middle of a copy.
    task automatic feed_phase(input int quota);
        int              goal;
        int              n;
        int              cut;
        int              r;
        oasm_pkg::t_byte b_out;
        goal = sent_items + quota;
        while (sent_items < goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                n   = (cur_len >= 1 && cur_len <= PATTERN_MAX) ? cur_len : $urandom_range(1, 8);
                cut = ($urandom_range(0, 99) < 25) ? $urandom_range(0, n - 1) : n;
                for (int b = 0; b < n; b++) begin
                    b_out = cur_pattern[8*b +: 8];
                    if (b == cut) b_out = b_out ^ 8'($urandom_range(1, 255));
                    send_text_byte(b_out, $urandom_range(0, 59) == 0);
                end
            end else if (r < 88) begin
                n = $urandom_range(1, 6);
                for (int b = 0; b < n; b++) begin
                    send_text_byte(alpha[$urandom_range(0, alpha_size - 1)],
                                   $urandom_range(0, 19) == 0);
                end
            end else begin
                send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        int directed_items;
        int phase;
        int len;
        int shape;
        int letters;
        int r;
        int quota;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Right after reset the length is zero, and a zero byte against
        // the all-zero pattern must still report nothing.
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h00, 1'b1);

        // One-byte pattern of all ones: every such byte is a match, also across the
        // end of a text, where the position restarts at zero.
        settle();
        program_matcher(oasm_pkg::t_len'(1), oasm_pkg::t_pattern'(8'hFF));
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'hFF, 1'b0);

        // Three-byte pattern "aba": overlapping hits at 0 and 2, then a text that ends
        // before it is long enough, then a hit at the start of a fresh text.
        settle();
        cur_pattern        = '1;
        cur_pattern[23:0]  = 24'h61_62_61;
        program_matcher(oasm_pkg::t_len'(3), cur_pattern);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b1);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b1);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b0);

        // A length above the pattern size must never report.
        settle();
        program_matcher(oasm_pkg::t_len'(33), '1);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        directed_items = sent_items;

        // Random part: one setting per phase. The first phases pin the extremes and the
        // idling experiments; after that lengths and pattern shapes are drawn at random,
        // mostly short so that matches are frequent.
        phase = 0;
        while (sent_items < directed_items + RANDOM_BYTES || phase < 7) begin
            settle();
            letters = $urandom_range(1, 4);
            shape   = 0;
            case (phase)
                0: begin
                    len   = PATTERN_MAX;
                    shape = 2;
                end
                1: len = 63;
                2: begin
                    len   = 0;
                    shape = 1;
                end
                3: len = PATTERN_MAX + 1;
                4: len = $urandom_range(1, 6);
                5: begin
                    len     = 1;
                    letters = 2;
                end
                6: len = PATTERN_MAX;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 10) len = PATTERN_MAX;
                    else if (r < 15) len = $urandom_range(PATTERN_MAX + 1, 63);
                    else if (r < 20) len = 0;
                    else if (r < 70) len = $urandom_range(1, 6);
                    else len = $urandom_range(7, PATTERN_MAX - 1);
                    r = $urandom_range(0, 99);
                    if (r < 15) shape = 1;
                    else if (r < 30) shape = 2;
                end
            endcase
            make_pattern(len, shape, letters);
            program_matcher(oasm_pkg::t_len'(len), cur_pattern);

            // Phase 4 runs with no idling on either side; phase 5 stalls the receiver
            // with a one-byte pattern from two letters, so the block must push back on requests.
            if (phase == 4) no_idle <= 1'b1;
            if (phase == 5) hold_requests <= hold_requests + 1;

            quota = 24 + 2 * ((len >= 1 && len <= PATTERN_MAX) ? len : 4);
            if (phase == 4) quota = NO_IDLE_ITEMS;
            feed_phase(quota);
            if (phase == 4) no_idle <= 1'b0;
            phase++;
        end

        // Drain: wait for the last predicted matches, then give a late result time to show.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_WAIT + 2) @(posedge clk);

        $display("summary: %0d text bytes (%0d directed) over %0d pattern settings",
                 sent_items, directed_items, settings_run);
        $display("summary: %0d match positions compared, %0d mismatches",
                 checked_count, fail_count);
        if (pending != 0) $error("%0d expected match positions never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
